// ===== rtl/tlpc_pkg.sv =====
// Shared types, register codes and constants for the traffic light phase controller.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package tlpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int DIR_COUNT  = 4;
    localparam int COUNT_W    = 8;
    localparam int QSUM_W     = 10;
    localparam int STAT_W     = 32;
    localparam int PHASE_W    = 3;

    // Register reset values
    localparam logic [7:0] GREEN_FLOOR_RST   = 8'd8;
    localparam logic [7:0] GREEN_CEILING_RST = 8'd25;
    localparam logic [5:0] SLOT_SECS_RST     = 6'd20;
    localparam logic [7:0] AMBER_SECS_RST    = 8'd3;
    localparam logic       ADAPTIVE_MODE_RST = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GREEN_FLOOR   = 3'd0,
        REG_GREEN_CEILING = 3'd1,
        REG_SLOT_SECS     = 3'd2,
        REG_AMBER_SECS    = 3'd3,
        REG_ADAPTIVE_MODE = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_EAST  = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [7:0] green_floor;
        logic [7:0] green_ceiling;
        logic [5:0] slot_secs;
        logic [7:0] amber_secs;
        logic       adaptive_mode;
    } cfg_t;

    // Indexed by direction code
    typedef struct packed {
        logic [DIR_COUNT-1:0][COUNT_W-1:0] demand;
        logic [DIR_COUNT-1:0][COUNT_W-1:0] queued;
    } tick_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_index;
        logic               phase_written;
        logic               yellow_shown;
        logic [STAT_W-1:0]  total_red_wait;
        logic [QSUM_W-1:0]  peak_combined_queue;
        logic [STAT_W-1:0]  combined_queue_total;
        logic [STAT_W-1:0]  ticks_seen;
    } result_t;

    // Green phase code of a direction: N0 E2 S4 W6
    function automatic logic [PHASE_W-1:0] green_of(input dir_t d);
        logic [PHASE_W-1:0] p;
        begin
            case (d)
                DIR_NORTH: p = 3'd0;
                DIR_SOUTH: p = 3'd4;
                DIR_EAST:  p = 3'd2;
                DIR_WEST:  p = 3'd6;
                default:   p = 3'd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== rtl/tlpc_cfg.sv =====
// Configuration register bank of the traffic light phase controller.
// Depends on tlpc_pkg.
`timescale 1ns / 1ps

module tlpc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tlpc_pkg::cfg_t                   cfg
);
    import tlpc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_floor   <= GREEN_FLOOR_RST;
            cfg_reg.green_ceiling <= GREEN_CEILING_RST;
            cfg_reg.slot_secs     <= SLOT_SECS_RST;
            cfg_reg.amber_secs    <= AMBER_SECS_RST;
            cfg_reg.adaptive_mode <= ADAPTIVE_MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GREEN_FLOOR:   cfg_reg.green_floor   <= cfg_data[7:0];
                REG_GREEN_CEILING: cfg_reg.green_ceiling <= cfg_data[7:0];
                REG_SLOT_SECS:     cfg_reg.slot_secs     <= cfg_data[5:0];
                REG_AMBER_SECS:    cfg_reg.amber_secs    <= cfg_data[7:0];
                REG_ADAPTIVE_MODE: cfg_reg.adaptive_mode <= cfg_data[0];
                default:           ;  // drop writes to unknown indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tlpc_core.sv =====
// Phase decision and statistics state of the traffic light phase controller.
// Computes one tick's result from the held state; state updates when step is high.
// Depends on tlpc_pkg.
`timescale 1ns / 1ps

module tlpc_core #(
    parameter int MAX_COUNT = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlpc_pkg::cfg_t    cfg,
    input  tlpc_pkg::tick_t   tick,
    input  logic              step,
    output tlpc_pkg::result_t result
);
    import tlpc_pkg::*;

    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    dir_t               current_dir_reg, current_dir_next;
    dir_t               pending_dir_reg, pending_dir_next;
    logic               in_yellow_reg, in_yellow_next;
    logic [CW-1:0]      elapsed_reg, elapsed_next;
    logic [7:0]         sched_pos_reg, sched_pos_next;
    logic [PHASE_W-1:0] last_phase_reg, last_phase_next;
    logic [STAT_W-1:0]  red_wait_reg, red_wait_next;
    logic [QSUM_W-1:0]  queue_peak_reg, queue_peak_next;
    logic [STAT_W-1:0]  queue_sum_reg, queue_sum_next;
    logic [STAT_W-1:0]  tick_total_reg, tick_total_next;

    logic [QSUM_W-1:0]  combined;
    logic [QSUM_W-1:0]  red;
    logic [STAT_W:0]    red_sum;
    logic [STAT_W:0]    q_sum;
    logic [STAT_W:0]    t_sum;
    logic [5:0]         fg;
    logic [7:0]         fg1, fg2, fg3, cycle_len;
    logic [7:0]         sched_inc;
    logic [CW-1:0]      elapsed_inc;
    logic [CMPW-1:0]    elapsed_cmp;
    dir_t               target;
    dir_t               best;
    logic [COUNT_W-1:0] best_val;
    logic               do_switch;
    logic               written;

    always_comb
    begin
        combined = '0;
        red      = '0;
        for (int d = 0; d < DIR_COUNT; d++)
        begin
            combined = combined + QSUM_W'(tick.queued[d]);
            // queued vehicles count as waiting unless their direction shows green
            if (in_yellow_reg || (current_dir_reg != dir_t'(2'(d))))
                red = red + QSUM_W'(tick.queued[d]);
        end

        red_sum = {1'b0, red_wait_reg} + (STAT_W + 1)'(red);
        q_sum   = {1'b0, queue_sum_reg} + (STAT_W + 1)'(combined);
        t_sum   = {1'b0, tick_total_reg} + (STAT_W + 1)'(1);
        red_wait_next   = red_sum[STAT_W] ? '1 : red_sum[STAT_W-1:0];
        queue_sum_next  = q_sum[STAT_W]   ? '1 : q_sum[STAT_W-1:0];
        tick_total_next = t_sum[STAT_W]   ? '1 : t_sum[STAT_W-1:0];
        queue_peak_next = (combined > queue_peak_reg) ? combined : queue_peak_reg;

        elapsed_inc = (elapsed_reg < CW'(MAX_COUNT)) ? elapsed_reg + 1'b1 : elapsed_reg;
        elapsed_cmp = CMPW'(elapsed_inc);

        // fixed green of zero acts as one
        fg        = (cfg.slot_secs == 6'd0) ? 6'd1 : cfg.slot_secs;
        fg1       = 8'(fg);
        fg2       = 8'({fg, 1'b0});
        fg3       = fg2 + fg1;
        cycle_len = {fg, 2'b00};
        sched_inc = sched_pos_reg + 8'd1;
        sched_pos_next = (sched_inc >= cycle_len) ? 8'd0 : sched_inc;

        // largest demand, ties to the lower direction code
        best     = DIR_NORTH;
        best_val = tick.demand[0];
        for (int d = 1; d < DIR_COUNT; d++)
        begin
            if (tick.demand[d] > best_val)
            begin
                best     = dir_t'(2'(d));
                best_val = tick.demand[d];
            end
        end

        // anticlockwise schedule: north, west, south, east
        if (!cfg.adaptive_mode)
        begin
            if (sched_pos_next < fg1)
                target = DIR_NORTH;
            else if (sched_pos_next < fg2)
                target = DIR_WEST;
            else if (sched_pos_next < fg3)
                target = DIR_SOUTH;
            else
                target = DIR_EAST;
            do_switch = (target != current_dir_reg);
        end
        else
        begin
            target    = best;
            do_switch = (elapsed_cmp >= CMPW'(cfg.green_floor)) &&
                        ((target != current_dir_reg) ||
                         (elapsed_cmp >= CMPW'(cfg.green_ceiling)));
        end

        current_dir_next = current_dir_reg;
        pending_dir_next = pending_dir_reg;
        in_yellow_next   = in_yellow_reg;
        last_phase_next  = last_phase_reg;
        elapsed_next     = elapsed_inc;
        written          = 1'b0;

        if (in_yellow_reg)
        begin
            if (elapsed_cmp >= CMPW'(cfg.amber_secs))
            begin
                current_dir_next = pending_dir_reg;
                last_phase_next  = green_of(pending_dir_reg);
                in_yellow_next   = 1'b0;
                elapsed_next     = '0;
                written          = 1'b1;
            end
        end
        else if (do_switch)
        begin
            last_phase_next  = green_of(current_dir_reg) + 3'd1;
            pending_dir_next = target;
            in_yellow_next   = 1'b1;
            elapsed_next     = '0;
            written          = 1'b1;
        end

        result.phase_index          = last_phase_next;
        result.phase_written        = written;
        result.yellow_shown         = in_yellow_next;
        result.total_red_wait       = red_wait_next;
        result.peak_combined_queue  = queue_peak_next;
        result.combined_queue_total = queue_sum_next;
        result.ticks_seen           = tick_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_dir_reg <= DIR_NORTH;
            pending_dir_reg <= DIR_NORTH;
            in_yellow_reg   <= 1'b0;
            elapsed_reg     <= '0;
            sched_pos_reg   <= '0;
            last_phase_reg  <= '0;
            red_wait_reg    <= '0;
            queue_peak_reg  <= '0;
            queue_sum_reg   <= '0;
            tick_total_reg  <= '0;
        end
        else if (step)
        begin
            current_dir_reg <= current_dir_next;
            pending_dir_reg <= pending_dir_next;
            in_yellow_reg   <= in_yellow_next;
            elapsed_reg     <= elapsed_next;
            sched_pos_reg   <= sched_pos_next;
            last_phase_reg  <= last_phase_next;
            red_wait_reg    <= red_wait_next;
            queue_peak_reg  <= queue_peak_next;
            queue_sum_reg   <= queue_sum_next;
            tick_total_reg  <= tick_total_next;
        end
    end

endmodule

// ===== rtl/traffic_light_phase_controller.sv =====
// Four-way traffic light phase controller, one tick beat in, one result beat out.
// An accepted beat is held in the input register, its result in the result register.
// Throughput: one beat per cycle, set by the combinational phase decision between
// the input register and the result register; stalls only under output back-pressure.
// Reset: rst_n clears control state and statistics; the data registers are not reset.
// Depends on tlpc_pkg, tlpc_cfg and tlpc_core.
`timescale 1ns / 1ps

module traffic_light_phase_controller #(
    parameter int MAX_COUNT = 255
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlpc_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       demand_north,
    input  logic [7:0]                       demand_south,
    input  logic [7:0]                       demand_east,
    input  logic [7:0]                       demand_west,
    input  logic [7:0]                       queued_north,
    input  logic [7:0]                       queued_south,
    input  logic [7:0]                       queued_east,
    input  logic [7:0]                       queued_west,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       phase_index,
    output logic                             phase_written,
    output logic                             yellow_shown,
    output logic [31:0]                      total_red_wait,
    output logic [9:0]                       peak_combined_queue,
    output logic [31:0]                      combined_queue_total,
    output logic [31:0]                      ticks_seen
);
    import tlpc_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    tick_t   tick_in;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t result;
    logic    step;
    logic    in_take;

    tlpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlpc_core #(
        .MAX_COUNT (MAX_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick_reg),
        .step   (step),
        .result (result)
    );

    always_comb
    begin
        tick_in.demand[DIR_NORTH] = demand_north;
        tick_in.demand[DIR_SOUTH] = demand_south;
        tick_in.demand[DIR_EAST]  = demand_east;
        tick_in.demand[DIR_WEST]  = demand_west;
        tick_in.queued[DIR_NORTH] = queued_north;
        tick_in.queued[DIR_SOUTH] = queued_south;
        tick_in.queued[DIR_EAST]  = queued_east;
        tick_in.queued[DIR_WEST]  = queued_west;
    end

    // advance the held beat when the result register is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            tick_reg <= tick_in;
        if (step)
            result_reg <= result;
    end

    assign out_valid            = out_valid_reg;
    assign phase_index          = result_reg.phase_index;
    assign phase_written        = result_reg.phase_written;
    assign yellow_shown         = result_reg.yellow_shown;
    assign total_red_wait       = result_reg.total_red_wait;
    assign peak_combined_queue  = result_reg.peak_combined_queue;
    assign combined_queue_total = result_reg.combined_queue_total;
    assign ticks_seen           = result_reg.ticks_seen;

endmodule
